// File: sv/lrc_pkg.sv
// Shared types, constants and command codes for the latency rate controller.
package lrc_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_MIN_RATE      = 3'd0;
  localparam logic [2:0] REG_RATE_FLOOR    = 3'd1;
  localparam logic [2:0] REG_SLOWDOWN_Q16  = 3'd2;
  localparam logic [2:0] REG_SPEEDUP_Q8    = 3'd3;
  localparam logic [2:0] REG_PROBLEM_TMO   = 3'd4;
  localparam logic [2:0] REG_MEASURE_WIN   = 3'd5;

  // Register reset values
  localparam logic [31:0] MIN_RATE_RST     = 32'd10000;
  localparam logic [31:0] RATE_FLOOR_RST   = 32'd20000;
  localparam logic [16:0] SLOWDOWN_RST     = 17'd58982;
  localparam logic [9:0]  SPEEDUP_RST      = 10'd282;
  localparam logic [15:0] PROBLEM_TMO_RST  = 16'd1000;
  localparam logic [15:0] MEASURE_WIN_RST  = 16'd250;

  // Divider geometry
  localparam int DIV_W     = 48;
  localparam int DIV_CNT_W = $clog2(DIV_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

  // Datapath commands
  typedef enum logic [3:0] {
    DP_NONE,
    DP_CAPTURE,
    DP_BYTES,
    DP_LAT,
    DP_DECIDE,
    DP_MUL_BYTES,
    DP_DIV_WIN,
    DP_WIN_DONE,
    DP_DIV_RATIO,
    DP_RATIO_DONE,
    DP_SCALE,
    DP_APPLY,
    DP_OUT
  } dp_op_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic ratio_path;
    logic measure;
    logic div_done;
    logic kept;
  } dp_stat_t;

endpackage

// File: sv/lrc_div.sv
// Restoring divider, one quotient bit per cycle.
module lrc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lrc_pkg::DIV_W-1:0]  dividend,
  input  logic [31:0]                divisor,
  output logic                       done,
  output logic [lrc_pkg::DIV_W-1:0]  quotient
);
  import lrc_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]          rem_r, rem_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [31:0]          dvs_r, dvs_nxt;
  logic [32:0]          trial;
  logic [32:0]          diff;
  logic                 ge;

  // One trial subtraction per step
  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[31:0] : trial[31:0];
      quo_nxt = {quo_r[DIV_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: sv/lrc_datapath.sv
// State, configuration, multiplier and divider of the rate controller.
module lrc_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  lrc_pkg::dp_op_t   op,
  output lrc_pkg::dp_stat_t stat,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_wdata,
  input  logic [15:0]       in_latency_ms,
  input  logic [15:0]       in_sent_length,
  input  logic [31:0]       in_now_ms,
  output logic [31:0]       out_send_rate,
  output logic              out_in_problem,
  output logic [31:0]       out_measured_rate
);
  import lrc_pkg::*;

  // Configuration
  logic [31:0] min_rate_r, rate_floor_r;
  logic [16:0] slowdown_r;
  logic [9:0]  speedup_r;
  logic [15:0] problem_tmo_r, measure_win_r;

  // Captured item
  logic [15:0] lat_r, len_r;
  logic [31:0] now_r;

  // Controller state
  logic [15:0] ring0_r, ring1_r;
  logic [15:0] local_min_r, global_min_r, newest_r, older_r;
  logic        problem_r;
  logic [31:0] since_r, rate_r, base_r, real_r, sum_r, win_start_r;
  logic [48:0] mul_r;
  logic        lt_r;
  logic [16:0] ratio_r;

  // Output register
  logic [31:0] o_rate_r, o_real_r;
  logic        o_problem_r;

  // Derived values
  logic [16:0] n_v, g_v, l_v;
  logic [19:0] g7, l5;
  logic [18:0] g3;
  logic [17:0] n2;
  logic [31:0] elapsed, win_e, half_base;
  logic        leave, emerg, rescue;
  logic [32:0] sum_add;
  logic [31:0] mul_a;
  logic [16:0] mul_b;
  logic [48:0] mul_p;
  logic        div_start;
  logic [DIV_W-1:0] div_dvd, div_q;
  logic [31:0] div_dvs;
  logic        div_done;
  logic [31:0] slow_v, fast_v;
  logic [33:0] real_x4, rate_p1;

  assign n_v = {1'b0, newest_r} + 17'd100;
  assign g_v = {1'b0, global_min_r} + 17'd100;
  assign l_v = {1'b0, local_min_r} + 17'd100;
  assign g7  = 20'(g_v) * 20'd7;
  assign g3  = 19'(g_v) * 19'd3;
  assign l5  = 20'(l_v) * 20'd5;
  assign n2  = {n_v, 1'b0};

  assign elapsed = now_r - since_r;
  assign win_e   = now_r - win_start_r;
  assign leave   = (19'(n_v) < g3) || (elapsed >= {16'd0, problem_tmo_r});
  assign emerg   = 20'(n_v) > g7;
  assign rescue  = 20'(n2) > l5;
  assign half_base = {1'b0, base_r[31:1]};
  assign sum_add = {1'b0, sum_r} + {17'd0, len_r};

  // Shared multiplier operands
  always_comb begin
    mul_a = base_r;
    mul_b = lt_r ? ratio_r : {7'd0, speedup_r};
    if (op == DP_MUL_BYTES) begin
      mul_a = sum_r;
      mul_b = 17'd1000;
    end
  end
  assign mul_p = 49'(mul_a) * 49'(mul_b);

  // Divider operands
  assign div_start = (op == DP_DIV_WIN) || (op == DP_DIV_RATIO);
  always_comb begin
    if (op == DP_DIV_RATIO) begin
      div_dvd = DIV_W'({({1'b0, older_r} + 17'd10), 16'd0});
      div_dvs = {15'd0, ({1'b0, newest_r} + 17'd10)};
    end else begin
      div_dvd = mul_r[DIV_W-1:0];
      div_dvs = win_e;
    end
  end

  lrc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  // Candidate rates after the ratio step
  assign slow_v  = (mul_r[47:16] < rate_floor_r) ? rate_floor_r : mul_r[47:16];
  assign fast_v  = (mul_r[48:40] != 9'd0) ? 32'hFFFF_FFFF : mul_r[39:8];
  assign real_x4 = {real_r, 2'b00};
  assign rate_p1 = {2'b00, rate_r} + 34'd1;

  assign stat.ratio_path = !problem_r && !emerg && !rescue;
  assign stat.measure    = (win_e != 32'd0) && (win_e >= {16'd0, measure_win_r});
  assign stat.div_done   = div_done;
  assign stat.kept       = !lt_r && (real_x4 < rate_p1);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_rate_r    <= MIN_RATE_RST;
      rate_floor_r  <= RATE_FLOOR_RST;
      slowdown_r    <= SLOWDOWN_RST;
      speedup_r     <= SPEEDUP_RST;
      problem_tmo_r <= PROBLEM_TMO_RST;
      measure_win_r <= MEASURE_WIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_RATE:     min_rate_r    <= cfg_wdata;
        REG_RATE_FLOOR:   rate_floor_r  <= cfg_wdata;
        REG_SLOWDOWN_Q16: slowdown_r    <= cfg_wdata[16:0];
        REG_SPEEDUP_Q8:   speedup_r     <= cfg_wdata[9:0];
        REG_PROBLEM_TMO:  problem_tmo_r <= cfg_wdata[15:0];
        REG_MEASURE_WIN:  measure_win_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Controller state updates per command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring0_r      <= '0;
      ring1_r      <= '0;
      local_min_r  <= 16'hFFFF;
      global_min_r <= 16'hFFFF;
      newest_r     <= '0;
      problem_r    <= 1'b0;
      since_r      <= '0;
      rate_r       <= MIN_RATE_RST;
      base_r       <= MIN_RATE_RST;
      real_r       <= '0;
      sum_r        <= '0;
      win_start_r  <= '0;
    end else begin
      unique case (op)
        DP_BYTES: begin
          sum_r <= sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];
        end
        DP_LAT: begin
          if (local_min_r > lat_r) local_min_r <= lat_r;
          if (global_min_r > lat_r) global_min_r <= lat_r;
          ring0_r  <= lat_r;
          ring1_r  <= ring0_r;
          newest_r <= (ring0_r < lat_r) ? ring0_r : lat_r;
        end
        DP_DECIDE: begin
          priority if (problem_r) begin
            if (leave) problem_r <= 1'b0;
            base_r <= rate_r;
          end else if (emerg) begin
            rate_r    <= min_rate_r;
            base_r    <= min_rate_r;
            since_r   <= now_r;
            problem_r <= 1'b1;
          end else if (rescue) begin
            rate_r      <= (half_base < rate_floor_r) ? rate_floor_r : half_base;
            base_r      <= (half_base < rate_floor_r) ? rate_floor_r : half_base;
            local_min_r <= newest_r;
          end else begin
          end
        end
        DP_WIN_DONE: begin
          real_r      <= (div_q[DIV_W-1:32] != '0) ? 32'hFFFF_FFFF : div_q[31:0];
          win_start_r <= now_r;
          sum_r       <= '0;
        end
        DP_APPLY: begin
          rate_r <= lt_r ? slow_v : fast_v;
          base_r <= lt_r ? slow_v : fast_v;
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (op == DP_CAPTURE) begin
      lat_r <= in_latency_ms;
      len_r <= in_sent_length;
      now_r <= in_now_ms;
    end
    if (op == DP_LAT) older_r <= (ring1_r < ring0_r) ? ring1_r : ring0_r;
    if (op == DP_MUL_BYTES || op == DP_SCALE) mul_r <= mul_p;
    if (op == DP_RATIO_DONE) begin
      lt_r    <= div_q < DIV_W'(slowdown_r);
      ratio_r <= div_q[16:0];
    end
    if (op == DP_OUT) begin
      o_rate_r    <= rate_r;
      o_problem_r <= problem_r;
      o_real_r    <= real_r;
    end
  end

  assign out_send_rate     = o_rate_r;
  assign out_in_problem    = o_problem_r;
  assign out_measured_rate = o_real_r;

endmodule

// File: sv/lrc_ctrl.sv
// Sequencer that steps the datapath through one item and drives the handshakes.
module lrc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_action,
  output logic              out_valid,
  input  logic              out_ready,
  input  lrc_pkg::dp_stat_t stat,
  output lrc_pkg::dp_op_t   op
);
  import lrc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_BYTES, ST_LAT, ST_DECIDE, ST_MULB, ST_DIVW_GO, ST_DIVW_WAIT,
    ST_DIVR_GO, ST_DIVR_WAIT, ST_SCALE, ST_APPLY, ST_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    op            = DP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op        = DP_CAPTURE;
          state_nxt = in_action ? ST_BYTES : ST_LAT;
        end
      end
      ST_BYTES: begin
        op        = DP_BYTES;
        state_nxt = ST_OUT;
      end
      ST_LAT: begin
        op        = DP_LAT;
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        op = DP_DECIDE;
        priority if (!stat.ratio_path) state_nxt = ST_OUT;
        else if (stat.measure)         state_nxt = ST_MULB;
        else                           state_nxt = ST_DIVR_GO;
      end
      ST_MULB: begin
        op        = DP_MUL_BYTES;
        state_nxt = ST_DIVW_GO;
      end
      ST_DIVW_GO: begin
        op        = DP_DIV_WIN;
        state_nxt = ST_DIVW_WAIT;
      end
      ST_DIVW_WAIT: begin
        if (stat.div_done) begin
          op        = DP_WIN_DONE;
          state_nxt = ST_DIVR_GO;
        end
      end
      ST_DIVR_GO: begin
        op        = DP_DIV_RATIO;
        state_nxt = ST_DIVR_WAIT;
      end
      ST_DIVR_WAIT: begin
        if (stat.div_done) begin
          op        = DP_RATIO_DONE;
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        op        = DP_SCALE;
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        // the kept case leaves rate and base alone
        if (!stat.kept) op = DP_APPLY;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          op            = DP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: sv/latency_rate_controller_core.sv
// Top level of the latency rate controller: sequencer plus datapath.
// A bytes-sent item runs capture, bytes and output; a latency item runs
// capture, latency, decide and output, with ratio division, scale and
// apply before output unless the outcome is problem, emergency or rescue.
// The long paths wait on the shared 48-step restoring divider, run once for
// the latency ratio and once for the throughput when the window is also
// recomputed. A finished result sits in an output register, so the next
// item is taken while it waits; rate_r resets to the min_rate reset value.
module latency_rate_controller_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [15:0] in_latency_ms,
  input  logic [15:0] in_sent_length,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_send_rate,
  output logic        out_in_problem,
  output logic [31:0] out_measured_rate,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import lrc_pkg::*;

  dp_op_t   op;
  dp_stat_t stat;

  lrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .op        (op)
  );

  lrc_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .op                (op),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_latency_ms     (in_latency_ms),
    .in_sent_length    (in_sent_length),
    .in_now_ms         (in_now_ms),
    .out_send_rate     (out_send_rate),
    .out_in_problem    (out_in_problem),
    .out_measured_rate (out_measured_rate)
  );

endmodule

// File: sv/lrc_checker.sv
// Port-level checks for the latency rate controller, bound to the top level.
module lrc_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_send_rate,
  input logic        out_in_problem,
  input logic [31:0] out_measured_rate
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_send_rate)
      && $stable(out_in_problem) && $stable(out_measured_rate))
    else $error("stalled result changed");

  // One item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

  // A new result comes only from a busy block
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without work");

  // Reset drops the result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind latency_rate_controller_core lrc_props u_lrc_props (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_send_rate     (out_send_rate),
  .out_in_problem    (out_in_problem),
  .out_measured_rate (out_measured_rate)
);

// File: tb/lrc_checker.sv
// Checker for the latency rate controller: watches both channels, predicts each result.
module lrc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_action,
  input  logic [15:0] in_latency_ms,
  input  logic [15:0] in_sent_length,
  input  logic [31:0] in_now_ms,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_send_rate,
  input  logic        out_in_problem,
  input  logic [31:0] out_measured_rate,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          pending_count
);
  import lrc_pkg::*;

  typedef struct packed {
    logic [31:0] send_rate;
    logic        in_problem;
    logic [31:0] measured_rate;
  } rate_result_t;

  rate_result_t expected_rates[$];

  // Register copies
  logic [31:0] min_rate, rate_floor;
  logic [16:0] slowdown_q16;
  logic [9:0]  speedup_q8;
  logic [15:0] problem_tmo, measure_win;

  // Controller state copies
  logic [15:0] lat_ring [3];
  int unsigned ring_idx;
  logic [15:0] local_min, global_min, newest_min;
  logic        problem_flag;
  logic [31:0] problem_since, rate_now, base_rate, real_rate, byte_sum, window_start;

  assign pending_count = expected_rates.size();

  function automatic logic [31:0] floor_clamp(logic [31:0] r);
    return (r < rate_floor) ? rate_floor : r;
  endfunction

  // Advance the predicted state by one latency sample
  task automatic apply_latency(logic [15:0] lat, logic [31:0] now);
    int unsigned p;
    logic [15:0] older;
    logic [31:0] n, g, l, elapsed, ratio;
    logic [63:0] prod;
    if (local_min > lat) local_min = lat;
    if (global_min > lat) global_min = lat;
    lat_ring[ring_idx] = lat;
    p = (ring_idx == 2) ? 0 : ring_idx + 1;
    ring_idx = p;
    newest_min = (lat_ring[(p+1)%3] < lat_ring[(p+2)%3]) ? lat_ring[(p+1)%3]
                                                          : lat_ring[(p+2)%3];
    older = (lat_ring[p] < lat_ring[(p+1)%3]) ? lat_ring[p] : lat_ring[(p+1)%3];
    n = newest_min + 32'd100;
    g = global_min + 32'd100;
    l = local_min + 32'd100;
    if (problem_flag) begin
      if (n < 3*g || (now - problem_since) >= {16'd0, problem_tmo}) problem_flag = 1'b0;
    end else if (n > 7*g) begin
      rate_now = min_rate;
      problem_since = now;
      problem_flag = 1'b1;
    end else if (2*n > 5*l) begin
      rate_now = floor_clamp(base_rate >> 1);
      local_min = newest_min;
    end else begin
      elapsed = now - window_start;
      if (elapsed != 0 && elapsed >= {16'd0, measure_win}) begin
        prod = (64'(byte_sum) * 64'd1000) / 64'(elapsed);
        real_rate = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
        window_start = now;
        byte_sum = 0;
      end
      prod = ((64'(older) + 64'd10) << 16) / (64'(newest_min) + 64'd10);
      ratio = prod[31:0];
      if (ratio < {15'd0, slowdown_q16}) begin
        prod = (64'(base_rate) * 64'(ratio)) >> 16;
        rate_now = floor_clamp(prod[31:0]);
      end else begin
        // hold base rate when measured throughput is too low
        if (64'(real_rate) * 4 < 64'(rate_now) + 1) return;
        prod = (64'(base_rate) * 64'(speedup_q8)) >> 8;
        rate_now = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
      end
    end
    base_rate = rate_now;
  endtask

  always @(posedge clk) begin
    rate_result_t exp_r;
    logic [32:0] sum;
    if (!rst_n) begin
      min_rate = MIN_RATE_RST; rate_floor = RATE_FLOOR_RST;
      slowdown_q16 = SLOWDOWN_RST; speedup_q8 = SPEEDUP_RST;
      problem_tmo = PROBLEM_TMO_RST; measure_win = MEASURE_WIN_RST;
      lat_ring[0] = 0; lat_ring[1] = 0; lat_ring[2] = 0; ring_idx = 0;
      local_min = 16'hFFFF; global_min = 16'hFFFF; newest_min = 0;
      problem_flag = 0; problem_since = 0; rate_now = MIN_RATE_RST;
      base_rate = MIN_RATE_RST; real_rate = 0; byte_sum = 0; window_start = 0;
      expected_rates.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_RATE:     min_rate = cfg_wdata;
          REG_RATE_FLOOR:   rate_floor = cfg_wdata;
          REG_SLOWDOWN_Q16: slowdown_q16 = cfg_wdata[16:0];
          REG_SPEEDUP_Q8:   speedup_q8 = cfg_wdata[9:0];
          REG_PROBLEM_TMO:  problem_tmo = cfg_wdata[15:0];
          REG_MEASURE_WIN:  measure_win = cfg_wdata[15:0];
          default: ;
        endcase
      end
      // Compare the result against the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_rates.size() == 0) begin
          $error("unexpected result: send_rate %0d", out_send_rate);
          fail_count++;
        end else begin
          exp_r = expected_rates.pop_front();
          if (out_send_rate !== exp_r.send_rate) begin
            $error("send_rate: expected %0d, got %0d", exp_r.send_rate, out_send_rate);
            fail_count++;
          end
          if (out_in_problem !== exp_r.in_problem) begin
            $error("in_problem: expected %0d, got %0d", exp_r.in_problem, out_in_problem);
            fail_count++;
          end
          if (out_measured_rate !== exp_r.measured_rate) begin
            $error("measured_rate: expected %0d, got %0d",
                   exp_r.measured_rate, out_measured_rate);
            fail_count++;
          end
        end
      end
      // Predict the result of each accepted item
      if (in_valid && in_ready) begin
        if (in_action) begin
          sum = 33'(byte_sum) + 33'(in_sent_length);
          byte_sum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end else begin
          apply_latency(in_latency_ms, in_now_ms);
        end
        exp_r = '{rate_now, problem_flag, real_rate};
        expected_rates.insert(expected_rates.size(), exp_r);
      end
    end
  end

endmodule

// File: tb/testbench.sv
// Top of the latency rate controller testbench: stimulus, configuration and verdict.
module testbench;
  import lrc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_action = 1'b0;
  logic [15:0] in_latency_ms = '0;
  logic [15:0] in_sent_length = '0;
  logic [31:0] in_now_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_send_rate;
  logic        out_in_problem;
  logic [31:0] out_measured_rate;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  int          fail_count;
  int          pending_count;
  int          stall_cycles = 0;
  int          stall_mode = 0;
  logic [31:0] clock_ms = '0;

  latency_rate_controller_core i_dut (.*);

  lrc_checker i_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stall pattern: phases of free flow, periodic and random stalls
  always @(posedge clk) begin
    stall_cycles <= stall_cycles + 1;
    if (stall_cycles % 300 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= (stall_cycles % 7) < 4;
      default: out_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    int idle_cycles;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("latency_rate_controller_core verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Present one item and hold it until accepted
  task automatic send_item(logic act, logic [15:0] lat, logic [15:0] len, logic [31:0] now);
    in_valid <= 1'b1;
    in_action <= act;
    in_latency_ms <= lat;
    in_sent_length <= len;
    in_now_ms <= now;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait for all results, then let the block settle
  task automatic drain();
    drop_valid();
    while (pending_count != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // Random traffic: latency trends with spikes and random samples, bytes in between
  task automatic random_phase(int count);
    int burst;
    logic [15:0] base_lat;
    base_lat = 16'($urandom_range(1, 400));
    burst = 0;
    for (int k = 0; k < count; k++) begin
      clock_ms += $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 400);
      case ($urandom_range(0, 9))
        0, 1, 2, 3:
          send_item(1'b1, 16'($urandom),
                    16'($urandom_range(0, 3) == 0 ? 32'hFFFF : $urandom), clock_ms);
        4:
          send_item(1'b0, 16'($urandom), 16'($urandom), clock_ms);
        5:
          send_item(1'b0,
                    16'(base_lat * $urandom_range(3, 9) + $urandom_range(0, 800)),
                    16'($urandom), clock_ms);
        default:
          send_item(1'b0, 16'(base_lat + $urandom_range(0, base_lat)), 16'($urandom),
                    clock_ms);
      endcase
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 1)) begin
          drop_valid();
          repeat ($urandom_range(0, 6)) @(posedge clk);
        end
      end else begin
        burst--;
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, both actions, each outcome
    send_item(1'b1, 16'hFFFF, 16'hFFFF, 32'd0);
    send_item(1'b1, 16'd0, 16'd0, 32'd10);
    send_item(1'b0, 16'd100, 16'd0, 32'd300);
    send_item(1'b0, 16'd100, 16'd0, 32'd600);
    send_item(1'b0, 16'd100, 16'd0, 32'd900);
    send_item(1'b0, 16'd0, 16'd0, 32'd900);
    send_item(1'b0, 16'd0, 16'd0, 32'd1300);
    send_item(1'b0, 16'hFFFF, 16'hFFFF, 32'd1400);
    send_item(1'b0, 16'hFFFF, 16'd0, 32'd1500);
    send_item(1'b0, 16'hFFFF, 16'd0, 32'd1600);
    send_item(1'b0, 16'd5, 16'd0, 32'd4000);
    send_item(1'b0, 16'd400, 16'd0, 32'd4100);
    send_item(1'b0, 16'd400, 16'd0, 32'd4200);
    for (int k = 0; k < 6; k++) send_item(1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(1'b0, 16'd20, 16'd0, 32'hFFFF_FFFF);
    send_item(1'b0, 16'd20, 16'd0, 32'hFFFF_FFFF);
    send_item(1'b0, 16'd20, 16'd0, 32'd200);
    drain();

    random_phase(150);
    drain();

    // Extreme settings: maximum min_rate, zero floor and timeout, fast speedup, zero window
    write_reg(REG_MIN_RATE, 32'hFFFF_FFFF);
    write_reg(REG_RATE_FLOOR, 32'd0);
    write_reg(REG_SLOWDOWN_Q16, 32'd65536);
    write_reg(REG_SPEEDUP_Q8, 32'd1023);
    write_reg(REG_PROBLEM_TMO, 32'd0);
    write_reg(REG_MEASURE_WIN, 32'd0);
    random_phase(120);
    drain();

    write_reg(REG_MIN_RATE, 32'd0);
    write_reg(REG_RATE_FLOOR, 32'hFFFF_FFFF);
    write_reg(REG_SLOWDOWN_Q16, 32'd0);
    write_reg(REG_SPEEDUP_Q8, 32'd256);
    write_reg(REG_PROBLEM_TMO, 32'd65535);
    write_reg(REG_MEASURE_WIN, 32'd65535);
    random_phase(100);
    drain();

    write_reg(REG_MIN_RATE, $urandom);
    write_reg(REG_RATE_FLOOR, $urandom_range(0, 100000));
    write_reg(REG_SLOWDOWN_Q16, $urandom_range(0, 65536));
    write_reg(REG_SPEEDUP_Q8, $urandom_range(256, 1023));
    write_reg(REG_PROBLEM_TMO, $urandom_range(0, 65535));
    write_reg(REG_MEASURE_WIN, $urandom_range(1, 65535));
    random_phase(130);
    drain();

    if (fail_count == 0) begin
      $display("latency_rate_controller_core verification clean");
    end else begin
      $display("latency_rate_controller_core verification failed");
    end
    $finish;
  end

endmodule
